// ----- rtl/tvet_pkg.sv -----
`default_nettype none
package tvet_pkg;

  // Quarter-wave sine table size and derived widths
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int TAB_AW           = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam int ONE_Q15          = 32768;
  localparam int ROUND_HALF       = 16384;

  // Datapath widths: coordinates carry headroom for the translated, rotated vertex
  localparam int CW = 36;
  localparam int TW = 17;
  localparam int PW = CW + TW;
  localparam int SW = PW + 1;

  // Lane pipeline: subtract, then multiply and sum for each of three rotations
  localparam int LANE_STAGES = 7;
  localparam int NUM_STAGES  = LANE_STAGES + 1;

  typedef enum logic [2:0] {
    REG_CAM_X  = 3'd0,
    REG_CAM_Y  = 3'd1,
    REG_CAM_Z  = 3'd2,
    REG_YAW    = 3'd3,
    REG_PITCH  = 3'd4,
    REG_ROLL   = 3'd5,
    REG_ORDER  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    AX_YAW   = 2'd0,
    AX_PITCH = 2'd1,
    AX_ROLL  = 2'd2
  } axis_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [31:0]   cam_x;
    logic signed [31:0]   cam_y;
    logic signed [31:0]   cam_z;
    logic                 order_mode;
    logic signed [TW-1:0] yaw_c;
    logic signed [TW-1:0] yaw_s;
    logic signed [TW-1:0] pitch_c;
    logic signed [TW-1:0] pitch_s;
    logic signed [TW-1:0] roll_c;
    logic signed [TW-1:0] roll_s;
  } cfg_t;

  typedef struct packed {
    logic [LANE_STAGES-1:0] en;
  } lane_ctrl_t;

  typedef struct packed {
    logic [23:0] a;
    logic [23:0] b;
    logic [23:0] c;
  } colors_t;

  typedef logic [15:0] sine_tab_t [0:SINE_TABLE_DEPTH];

  // Build the Q1.15 quarter wave by a Taylor series in Q30 at elaboration
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = PI_HALF_Q30 * 64'(k) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 6;
      if (sum > term) sum = sum - term; else sum = '0;
      term = ((term * x2) >> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 42;
      if (sum > term) sum = sum - term; else sum = '0;
      term = ((term * x2) >> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 110;
      if (sum > term) sum = sum - term; else sum = '0;
      term = ((term * x2) >> 30) / 156;
      sum  = sum + term;
      e    = (sum + 64'd16384) >> 15;
      if (e > 64'(ONE_Q15)) e = 64'(ONE_Q15);
      tab[k] = e[15:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  // Sine of a binary angle, folded from the quarter wave
  function automatic logic signed [TW-1:0] sine_of(input logic [15:0] a);
    logic [TAB_AW+13:0] prod;
    logic [TAB_AW-1:0]  i;
    logic [TAB_AW-1:0]  idx;
    logic [TW-1:0]      v;
    prod = (TAB_AW + 14)'(a[13:0]) * (TAB_AW + 14)'(SINE_TABLE_DEPTH);
    i    = prod[14 +: TAB_AW];
    idx  = a[14] ? (TAB_AW'(SINE_TABLE_DEPTH) - i) : i;
    v    = {1'b0, SINE_TAB[idx]};
    return a[15] ? $signed(-v) : $signed(v);
  endfunction

  // Clamp a wide coordinate to signed 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] hi;
    logic signed [CW-1:0] lo;
    hi = CW'(33'sh0_7FFF_FFFF);
    lo = CW'(33'sh1_8000_0000);
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tvet_in_if.sv -----
`default_nettype none
interface tvet_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] v1_x;
  logic signed [31:0] v1_y;
  logic signed [31:0] v1_z;
  logic signed [31:0] v2_x;
  logic signed [31:0] v2_y;
  logic signed [31:0] v2_z;
  logic signed [31:0] v3_x;
  logic signed [31:0] v3_y;
  logic signed [31:0] v3_z;
  logic [23:0]        color_a;
  logic [23:0]        color_b;
  logic [23:0]        color_c;

  modport source (output valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
                  color_a, color_b, color_c, input ready);
  modport sink   (input valid, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z,
                  color_a, color_b, color_c, output ready);
endinterface
`default_nettype wire

// ----- rtl/tvet_out_if.sv -----
`default_nettype none
interface tvet_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] t1_x;
  logic signed [31:0] t1_y;
  logic signed [31:0] t1_z;
  logic signed [31:0] t2_x;
  logic signed [31:0] t2_y;
  logic signed [31:0] t2_z;
  logic signed [31:0] t3_x;
  logic signed [31:0] t3_y;
  logic signed [31:0] t3_z;
  logic [23:0]        out_color_a;
  logic [23:0]        out_color_b;
  logic [23:0]        out_color_c;

  modport source (output valid, t1_x, t1_y, t1_z, t2_x, t2_y, t2_z, t3_x, t3_y, t3_z,
                  out_color_a, out_color_b, out_color_c, input ready);
  modport sink   (input valid, t1_x, t1_y, t1_z, t2_x, t2_y, t2_z, t3_x, t3_y, t3_z,
                  out_color_a, out_color_b, out_color_c, output ready);
endinterface
`default_nettype wire

// ----- rtl/tvet_cfg_if.sv -----
`default_nettype none
interface tvet_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/triangle_vertex_euler_transform.sv -----
`default_nettype none
// Triangle vertex transform: one triangle word in and one out per cycle while out_ch.ready
// stays high; a word passes the lane stages and then the output register. Three vertex lanes run side by side,
// each a seven-stage pipeline (camera subtract, then a multiply stage and a sum stage
// for each of the three rotations) feeding a shared output register; every stage holds
// on its own, so a stalled output fills the pipeline before in_ch.ready drops. A write to
// an angle register refreshes its cosine and sine from the quarter-wave table in the same
// register update as the write; write configuration only while no triangle is in flight.
module triangle_vertex_euler_transform import tvet_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  tvet_in_if.sink   in_ch,
  tvet_out_if.source out_ch,
  tvet_cfg_if.sink  cfg_ch
);

  cfg_t                  cfg;
  lane_ctrl_t            ctrl;
  logic [NUM_STAGES-1:0] en;
  logic [LANE_STAGES-1:0] vld_r;
  logic                  out_valid_r;
  colors_t               col_r [LANE_STAGES];
  colors_t               col_in;
  logic signed [31:0]    tx [3];
  logic signed [31:0]    ty [3];
  logic signed [31:0]    tz [3];

  tvet_trig u_trig (.clk(clk), .rst_n(rst_n), .cfg_ch(cfg_ch), .cfg(cfg));

  // Stage enables: a stage advances when empty or when the next one advances
  always_comb begin
    en[NUM_STAGES-1] = !out_valid_r || out_ch.ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign ctrl.en     = en[LANE_STAGES-1:0];
  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < LANE_STAGES; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
      if (en[NUM_STAGES-1]) out_valid_r <= vld_r[LANE_STAGES-1];
    end
  end

  // Colours ride alongside the lanes
  assign col_in = '{a: in_ch.color_a, b: in_ch.color_b, c: in_ch.color_c};

  always_ff @(posedge clk) begin
    if (en[0]) col_r[0] <= col_in;
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (en[k]) col_r[k] <= col_r[k-1];
    end
  end

  tvet_lane u_lane1 (.clk(clk), .ctrl(ctrl), .cfg(cfg),
                     .v_x(in_ch.v1_x), .v_y(in_ch.v1_y), .v_z(in_ch.v1_z),
                     .t_x(tx[0]), .t_y(ty[0]), .t_z(tz[0]));
  tvet_lane u_lane2 (.clk(clk), .ctrl(ctrl), .cfg(cfg),
                     .v_x(in_ch.v2_x), .v_y(in_ch.v2_y), .v_z(in_ch.v2_z),
                     .t_x(tx[1]), .t_y(ty[1]), .t_z(tz[1]));
  tvet_lane u_lane3 (.clk(clk), .ctrl(ctrl), .cfg(cfg),
                     .v_x(in_ch.v3_x), .v_y(in_ch.v3_y), .v_z(in_ch.v3_z),
                     .t_x(tx[2]), .t_y(ty[2]), .t_z(tz[2]));

  // Merge the three lanes and the colours into the output word
  always_ff @(posedge clk) begin
    if (en[NUM_STAGES-1]) begin
      out_ch.t1_x        <= tx[0];
      out_ch.t1_y        <= ty[0];
      out_ch.t1_z        <= tz[0];
      out_ch.t2_x        <= tx[1];
      out_ch.t2_y        <= ty[1];
      out_ch.t2_z        <= tz[1];
      out_ch.t3_x        <= tx[2];
      out_ch.t3_y        <= ty[2];
      out_ch.t3_z        <= tz[2];
      out_ch.out_color_a <= col_r[LANE_STAGES-1].a;
      out_ch.out_color_b <= col_r[LANE_STAGES-1].b;
      out_ch.out_color_c <= col_r[LANE_STAGES-1].c;
    end
  end

  assign out_ch.valid = out_valid_r;

  // An accepted word enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted word missing from first stage");

  // A full pipeline behind a stalled output refuses new words
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r && out_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input accepted with pipeline full and output stalled");

  // Cosines come out of reset at one
  a_reset_trig: assert property (@(posedge clk)
    (rst_n && $past(!rst_n) && !$past(cfg_ch.valid)) |->
      (cfg.yaw_c == TW'(ONE_Q15) && cfg.pitch_c == TW'(ONE_Q15) &&
       cfg.roll_c == TW'(ONE_Q15)))
    else $error("rotation cosines not at one after reset");

endmodule
`default_nettype wire

// ----- rtl/tvet_trig.sv -----
`default_nettype none
module tvet_trig import tvet_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tvet_cfg_if.sink    cfg_ch,
  output cfg_t        cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr;

  assign cfg_ch.ready = 1'b1;
  assign wr = cfg_ch.valid;

  // Decode the register word; refresh the sine/cosine pair on an angle write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_CAM_X: cfg_nxt.cam_x = $signed(cfg_ch.data);
        REG_CAM_Y: cfg_nxt.cam_y = $signed(cfg_ch.data);
        REG_CAM_Z: cfg_nxt.cam_z = $signed(cfg_ch.data);
        REG_YAW: begin
          cfg_nxt.yaw_c = sine_of(cfg_ch.data[15:0] + 16'd16384);
          cfg_nxt.yaw_s = sine_of(cfg_ch.data[15:0]);
        end
        REG_PITCH: begin
          cfg_nxt.pitch_c = sine_of(cfg_ch.data[15:0] + 16'd16384);
          cfg_nxt.pitch_s = sine_of(cfg_ch.data[15:0]);
        end
        REG_ROLL: begin
          cfg_nxt.roll_c = sine_of(cfg_ch.data[15:0] + 16'd16384);
          cfg_nxt.roll_s = sine_of(cfg_ch.data[15:0]);
        end
        REG_ORDER: cfg_nxt.order_mode = cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{cam_x: '0, cam_y: '0, cam_z: '0, order_mode: 1'b0,
                 yaw_c: TW'(ONE_Q15), yaw_s: '0,
                 pitch_c: TW'(ONE_Q15), pitch_s: '0,
                 roll_c: TW'(ONE_Q15), roll_s: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ----- rtl/tvet_rot.sv -----
`default_nettype none
module tvet_rot import tvet_pkg::*; (
  input  wire logic  clk,
  input  wire logic  en_mul,
  input  wire logic  en_add,
  input  wire axis_t axis,
  input  wire cfg_t  cfg,
  input  wire vec_t  p_in,
  output vec_t       p_out
);

  logic signed [CW-1:0] u;
  logic signed [CW-1:0] w;
  logic signed [CW-1:0] t;
  logic signed [TW-1:0] c;
  logic signed [TW-1:0] s;

  logic signed [PW-1:0] uc_r, ws_r, us_r, wc_r;
  logic signed [CW-1:0] t_r;
  axis_t                axis_r;

  logic signed [SW-1:0] d1, d2;
  logic signed [SW-1:0] sh1, sh2;
  logic signed [CW-1:0] u_new, w_new;
  vec_t                 p_r;
  vec_t                 p_nxt;

  // Pick the plane: u' = u*c - w*s, w' = u*s + w*c
  always_comb begin
    case (axis)
      AX_YAW: begin
        u = p_in.z; w = p_in.x; t = p_in.y; c = cfg.yaw_c; s = cfg.yaw_s;
      end
      AX_PITCH: begin
        u = p_in.y; w = p_in.z; t = p_in.x; c = cfg.pitch_c; s = cfg.pitch_s;
      end
      default: begin
        u = p_in.x; w = p_in.y; t = p_in.z; c = cfg.roll_c; s = cfg.roll_s;
      end
    endcase
  end

  // Multiply stage
  always_ff @(posedge clk) begin
    if (en_mul) begin
      uc_r   <= PW'(u) * PW'(c);
      ws_r   <= PW'(w) * PW'(s);
      us_r   <= PW'(u) * PW'(s);
      wc_r   <= PW'(w) * PW'(c);
      t_r    <= t;
      axis_r <= axis;
    end
  end

  // Sum, round half up and put the plane back
  always_comb begin
    d1    = SW'(uc_r) - SW'(ws_r);
    d2    = SW'(us_r) + SW'(wc_r);
    sh1   = (d1 + SW'(ROUND_HALF)) >>> 15;
    sh2   = (d2 + SW'(ROUND_HALF)) >>> 15;
    u_new = sh1[CW-1:0];
    w_new = sh2[CW-1:0];
    case (axis_r)
      AX_YAW: begin
        p_nxt.z = u_new; p_nxt.x = w_new; p_nxt.y = t_r;
      end
      AX_PITCH: begin
        p_nxt.y = u_new; p_nxt.z = w_new; p_nxt.x = t_r;
      end
      default: begin
        p_nxt.x = u_new; p_nxt.y = w_new; p_nxt.z = t_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_add) p_r <= p_nxt;
  end

  assign p_out = p_r;

endmodule
`default_nettype wire

// ----- rtl/tvet_lane.sv -----
`default_nettype none
module tvet_lane import tvet_pkg::*; (
  input  wire logic               clk,
  input  wire lane_ctrl_t         ctrl,
  input  wire cfg_t               cfg,
  input  wire logic signed [31:0] v_x,
  input  wire logic signed [31:0] v_y,
  input  wire logic signed [31:0] v_z,
  output logic signed [31:0]      t_x,
  output logic signed [31:0]      t_y,
  output logic signed [31:0]      t_z
);

  vec_t  d_r;
  vec_t  r0, r1, r2;
  axis_t ax_first;
  axis_t ax_last;

  // Translate by the camera position, exact difference
  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      d_r.x <= CW'(v_x) - CW'(cfg.cam_x);
      d_r.y <= CW'(v_y) - CW'(cfg.cam_y);
      d_r.z <= CW'(v_z) - CW'(cfg.cam_z);
    end
  end

  assign ax_first = cfg.order_mode ? AX_ROLL : AX_YAW;
  assign ax_last  = cfg.order_mode ? AX_YAW  : AX_ROLL;

  tvet_rot u_rot0 (.clk(clk), .en_mul(ctrl.en[1]), .en_add(ctrl.en[2]), .axis(ax_first),
                   .cfg(cfg), .p_in(d_r), .p_out(r0));
  tvet_rot u_rot1 (.clk(clk), .en_mul(ctrl.en[3]), .en_add(ctrl.en[4]), .axis(AX_PITCH),
                   .cfg(cfg), .p_in(r0), .p_out(r1));
  tvet_rot u_rot2 (.clk(clk), .en_mul(ctrl.en[5]), .en_add(ctrl.en[6]), .axis(ax_last),
                   .cfg(cfg), .p_in(r1), .p_out(r2));

  assign t_x = sat32(r2.x);
  assign t_y = sat32(r2.y);
  assign t_z = sat32(r2.z);

endmodule
`default_nettype wire

// ----- tb/sv/tvet_euler_checker.sv -----
`timescale 1ns / 1ps
module tvet_euler_checker import tvet_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  tvet_in_if.sink   in_mon,
  tvet_out_if.sink  out_mon,
  tvet_cfg_if.sink  cfg_mon,
  output int        fail_count,
  output int        pending_count
);

  typedef struct {
    logic signed [31:0] t [9];
    logic [23:0]        col [3];
  } tri_word_t;

  tri_word_t expected_tris [$];
  logic [15:0] quarter_wave [0:SINE_TABLE_DEPTH];
  longint cam [3];
  longint cos_v [3];
  longint sin_v [3];
  logic   roll_first;

  // Build the quarter-wave sine table in Q30, rounded to Q15
  initial begin
    longint unsigned x, x2, term, acc, e;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = 64'd1686629713 * longint'(k) / SINE_TABLE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int n = 1; n <= 6; n++) begin
        term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = (acc > term) ? acc - term : 0;
        else acc = acc + term;
      end
      e = (acc + 16384) >> 15;
      if (e > 32768) e = 32768;
      quarter_wave[k] = e[15:0];
    end
  end

  function automatic longint angle_sine(input logic [15:0] a);
    int unsigned i;
    longint v;
    i = (int'(a[13:0]) * SINE_TABLE_DEPTH) >> 14;
    v = a[14] ? quarter_wave[SINE_TABLE_DEPTH - i] : quarter_wave[i];
    return a[15] ? -v : v;
  endfunction

  function automatic longint round_q15(input longint v);
    return (v + 16384) >>> 15;
  endfunction

  // Rotate about one axis: 0 yaw, 1 pitch, 2 roll
  function automatic void rotate_axis(inout longint p [3], input int ax);
    longint c, s, a, b;
    c = cos_v[ax];
    s = sin_v[ax];
    case (ax)
      0: begin
        a = round_q15(p[0] * c + p[2] * s);
        b = round_q15(p[2] * c - p[0] * s);
        p[0] = a; p[2] = b;
      end
      1: begin
        a = round_q15(p[1] * c - p[2] * s);
        b = round_q15(p[1] * s + p[2] * c);
        p[1] = a; p[2] = b;
      end
      default: begin
        a = round_q15(p[0] * c - p[1] * s);
        b = round_q15(p[0] * s + p[1] * c);
        p[0] = a; p[1] = b;
      end
    endcase
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic tri_word_t transform_triangle(input logic signed [31:0] v [9],
                                                   input logic [23:0] col [3]);
    tri_word_t r;
    longint p [3];
    for (int n = 0; n < 3; n++) begin
      for (int a = 0; a < 3; a++) p[a] = longint'(v[3 * n + a]) - cam[a];
      if (roll_first) begin
        rotate_axis(p, 2); rotate_axis(p, 1); rotate_axis(p, 0);
      end else begin
        rotate_axis(p, 0); rotate_axis(p, 1); rotate_axis(p, 2);
      end
      for (int a = 0; a < 3; a++) r.t[3 * n + a] = clamp32(p[a]);
    end
    r.col = col;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  assign pending_count = expected_tris.size();

  // Track configuration, predict on input words, compare on output words
  always @(posedge clk) begin
    logic signed [31:0] vin [9];
    logic signed [31:0] vout [9];
    logic [23:0] cin [3];
    logic [23:0] cout [3];
    tri_word_t exp_w;
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        cam[a] = 0; cos_v[a] = 32768; sin_v[a] = 0;
      end
      roll_first = 1'b0;
      fail_count = 0;
      expected_tris.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_CAM_X: cam[0] = longint'($signed(cfg_mon.data));
          REG_CAM_Y: cam[1] = longint'($signed(cfg_mon.data));
          REG_CAM_Z: cam[2] = longint'($signed(cfg_mon.data));
          REG_YAW, REG_PITCH, REG_ROLL: begin
            int ax;
            ax = int'(cfg_mon.index) - int'(REG_YAW);
            sin_v[ax] = angle_sine(cfg_mon.data[15:0]);
            cos_v[ax] = angle_sine(cfg_mon.data[15:0] + 16'd16384);
          end
          REG_ORDER: roll_first = cfg_mon.data[0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        vin = '{in_mon.v1_x, in_mon.v1_y, in_mon.v1_z, in_mon.v2_x, in_mon.v2_y,
                in_mon.v2_z, in_mon.v3_x, in_mon.v3_y, in_mon.v3_z};
        cin = '{in_mon.color_a, in_mon.color_b, in_mon.color_c};
        expected_tris.push_back(transform_triangle(vin, cin));
      end
      if (out_mon.valid && out_mon.ready) begin
        vout = '{out_mon.t1_x, out_mon.t1_y, out_mon.t1_z, out_mon.t2_x, out_mon.t2_y,
                 out_mon.t2_z, out_mon.t3_x, out_mon.t3_y, out_mon.t3_z};
        cout = '{out_mon.out_color_a, out_mon.out_color_b, out_mon.out_color_c};
        if (expected_tris.size() == 0) begin
          $display("ERROR %0t: result word with nothing expected", $time);
          fail_count++;
        end else begin
          exp_w = expected_tris.pop_front();
          for (int k = 0; k < 9; k++)
            if (vout[k] !== exp_w.t[k])
              report_mismatch($sformatf("coord %0d", k), vout[k], exp_w.t[k]);
          for (int k = 0; k < 3; k++)
            if (cout[k] !== exp_w.col[k])
              report_mismatch($sformatf("colour %0d", k), cout[k], exp_w.col[k]);
        end
      end
    end
  end

endmodule

// ----- tb/sv/tb_triangle_vertex_euler_transform.sv -----
`timescale 1ns / 1ps
module tb_triangle_vertex_euler_transform import tvet_pkg::*;;

  localparam int LATENCY     = 8;
  localparam int IDLE_LIMIT  = 20000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   idle_cycles;
  logic long_hold;

  tvet_in_if  in_ch ();
  tvet_out_if out_ch ();
  tvet_cfg_if cfg_ch ();

  triangle_vertex_euler_transform u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  tvet_euler_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  // Receiver: own stall pattern, with a long hold-off when asked
  initial begin
    int mode;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(5, 60)) begin
        @(posedge clk);
        if (long_hold) out_ch.ready <= 1'b0;
        else case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 3) != 0);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Watchdog on accepted words
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk iff cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain: wait for every expected word, then let the pipeline settle
  task automatic drain();
    @(posedge clk iff pending_count == 0);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic send_tri(input logic signed [31:0] v [9], input logic [23:0] c [3]);
    in_ch.valid <= 1'b1;
    {in_ch.v1_x, in_ch.v1_y, in_ch.v1_z} <= {v[0], v[1], v[2]};
    {in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} <= {v[3], v[4], v[5]};
    {in_ch.v3_x, in_ch.v3_y, in_ch.v3_z} <= {v[6], v[7], v[8]};
    {in_ch.color_a, in_ch.color_b, in_ch.color_c} <= {c[0], c[1], c[2]};
    @(posedge clk iff in_ch.ready);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(0, 255)) - 32'd128) <<< 16;
      3: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      default: return $urandom;
    endcase
  endfunction

  // Send bursts, idling a random gap after some of them
  task automatic send_random(input int count);
    logic signed [31:0] v [9];
    logic [23:0] c [3];
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && count > 0) begin
        foreach (v[k]) v[k] = rand_coord();
        foreach (c[k]) c[k] = 24'($urandom_range(0, 24'hFF_FFFF));
        send_tri(v, c);
        burst--; count--;
      end
      if ($urandom_range(0, 2) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  task automatic random_config();
    write_reg(REG_CAM_X, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h3F_FFFF));
    write_reg(REG_CAM_Y, $urandom);
    write_reg(REG_CAM_Z, ($urandom_range(0, 1)) ? 32'h8000_0000 : $urandom_range(0, 32'hFFFF));
    write_reg(REG_YAW, $urandom);
    write_reg(REG_PITCH, $urandom);
    write_reg(REG_ROLL, $urandom);
    write_reg(REG_ORDER, $urandom);
  endtask

  initial begin
    logic signed [31:0] v [9];
    logic [23:0] c [3];
    logic [15:0] angles [6];
    rst_n = 1'b0;
    long_hold = 1'b0;
    in_ch.valid = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_CAM_X;
    cfg_ch.data = '0;
    {in_ch.v1_x, in_ch.v1_y, in_ch.v1_z, in_ch.v2_x, in_ch.v2_y, in_ch.v2_z} = '0;
    {in_ch.v3_x, in_ch.v3_y, in_ch.v3_z} = '0;
    {in_ch.color_a, in_ch.color_b, in_ch.color_c} = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state with extremes and plain values
    v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh0001_0000,
          32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
    c = '{24'hFF_FFFF, 24'h0, 24'h5A_A55A};
    send_tri(v, c);
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    c = '{24'h0, 24'hFF_FFFF, 24'hA5_5AA5};
    send_tri(v, c);
    in_ch.valid <= 1'b0;
    drain();

    // Directed: quadrant edges and extreme camera, both orders, saturation
    angles = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF, 16'h2000};
    for (int k = 0; k < 6; k++) begin
      write_reg(REG_CAM_X, (k % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF);
      write_reg(REG_CAM_Y, (k % 2) ? 32'h7FFF_FFFF : 32'h0);
      write_reg(REG_CAM_Z, 32'hFFFF_0000);
      write_reg(REG_YAW, {16'hFFFF, angles[k]});
      write_reg(REG_PITCH, angles[(k + 1) % 6]);
      write_reg(REG_ROLL, angles[(k + 3) % 6]);
      write_reg(REG_ORDER, {31'h7FFF_FFFF, k[0]});
      v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
            32'sh8000_0000, 32'sh8000_0000, 32'sh1234_5678, -5, 32'sh0000_8000};
      c = '{24'h12_3456, 24'h80_0001, 24'h7F_FFFE};
      send_tri(v, c);
      in_ch.valid <= 1'b0;
      drain();
    end

    // Random phases with fresh settings
    for (int ph = 0; ph < 6; ph++) begin
      random_config();
      send_random(150);
      drain();
    end

    // Fill the pipeline against a long receiver hold-off
    long_hold = 1'b1;
    fork
      send_random(60);
      begin
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end
    join
    drain();

    // Back to reset-like settings, then more random traffic
    write_reg(REG_CAM_X, 0); write_reg(REG_CAM_Y, 0); write_reg(REG_CAM_Z, 0);
    write_reg(REG_YAW, 0); write_reg(REG_PITCH, 0); write_reg(REG_ROLL, 0);
    write_reg(REG_ORDER, 0);
    send_random(100);
    drain();
    random_config();
    send_random(370);
    drain();

    if (fail_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_count != 0) $display("ERROR: %0d result words never came", pending_count);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
